// File: rtl/double_ended_queue_top_defines.svh
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, disabled during reset.
`define DQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// File: rtl/dq_pkg.sv
// Request codes and fixed widths for the deque.
package dq_pkg;

  localparam int REQ_W = 3;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_PEEK_FRONT = 3'd4;
  localparam req_t REQ_PEEK_BACK  = 3'd5;

endpackage

// File: rtl/double_ended_queue_top.sv
// Bounded deque of signed words held in a single ring-buffer memory.
//
// Usage:
//   Input channel: drive in_req_type and in_value_in with start high; the
//   item is taken at any rising edge where start is high and busy is low.
//   busy is high only while rst_n is low, so out of reset an item can be
//   given in every cycle.
//   Result channel: exactly one result per item, shown for one cycle with
//   out_valid high, in the cycle right after the item was taken.
//   Results leave at one per cycle; the receiver cannot hold them off.
//   Throughput: one item per cycle. Pointers and count update at accept; the
//   memory does at most one access per item (write for a push, read for a pop or a
//   peek) and its registered read data feeds out_value_out directly.
//   A push followed at once by a read of the same entry is safe: the write
//   lands at the accept edge, the read is sampled at the next edge.
//   Reset (rst_n low, synchronous) empties the queue: both pointers and the
//   count go to zero and no result is pending. The memory is not cleared;
//   only occupied entries are ever read.
//   Push into a full queue is refused and flagged with out_dropped.
//   Pops and peeks on an empty queue return -1 with out_value_valid low.
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [REQ_W-1:0]             in_req_type,
  input  logic signed [DATA_WIDTH-1:0] in_value_in,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_value_out,
  output logic                         out_value_valid,
  output logic [CW-1:0]                out_occupancy,
  output logic                         out_is_empty,
  output logic                         out_dropped
);

  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic          vld_r, vld_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] occ_r;
  logic          empty_r;
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic          acc;
  logic          full, empty;
  logic          we, re;
  logic [AW-1:0] addr;
  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;

  // no item is taken while in reset
  assign busy  = !rst_n;
  assign acc   = start && !busy;
  assign full  = (count_r >= CNT_FULL);
  assign empty = (count_r == '0);

  assign front_inc = (front_r == PTR_LAST) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? PTR_LAST : front_r - AW'(1);
  assign back_inc  = (back_r == PTR_LAST) ? '0 : back_r + AW'(1);
  assign back_dec  = (back_r == '0) ? PTR_LAST : back_r - AW'(1);

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    we        = 1'b0;
    re        = 1'b0;
    addr      = front_r;
    vld_nxt   = 1'b0;
    drop_nxt  = 1'b0;
    if (acc) begin
      unique case (in_req_type)
        REQ_PUSH_FRONT: begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            addr      = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            addr      = back_r;
            back_nxt  = back_inc;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (!empty) begin
            re        = 1'b1;
            vld_nxt   = 1'b1;
            addr      = front_r;
            front_nxt = front_inc;
            count_nxt = count_r - CW'(1);
          end
        end
        REQ_POP_BACK: begin
          if (!empty) begin
            re        = 1'b1;
            vld_nxt   = 1'b1;
            addr      = back_dec;
            back_nxt  = back_dec;
            count_nxt = count_r - CW'(1);
          end
        end
        REQ_PEEK_FRONT: begin
          if (!empty) begin
            re      = 1'b1;
            vld_nxt = 1'b1;
            addr    = front_r;
          end
        end
        REQ_PEEK_BACK: begin
          if (!empty) begin
            re      = 1'b1;
            vld_nxt = 1'b1;
            addr    = back_dec;
          end
        end
        default: ;  // unused codes change nothing
      endcase
    end
  end

  // single-port ring storage, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= in_value_in;
    end
    if (re) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      out_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      vld_r   <= vld_nxt;
      drop_r  <= drop_nxt;
      occ_r   <= count_nxt;
      empty_r <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_out   = vld_r ? rd_data_r : '1;
  assign out_value_valid = vld_r;
  assign out_occupancy   = occ_r;
  assign out_is_empty    = empty_r;
  assign out_dropped     = drop_r;

  `DQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL)
  `DQ_ASSERT_NXT(a_result_follows, clk, rst_n, acc, out_valid)
  `DQ_ASSERT_NXT(a_no_spurious_result, clk, rst_n, !acc, !out_valid)
  `DQ_ASSERT_IMP(a_drop_no_value, clk, rst_n, out_valid && out_dropped, !out_value_valid)
  `DQ_ASSERT_IMP(a_ptr_gap, clk, rst_n, 1'b1,
    ((AW+2)'(front_r) + (AW+2)'(count_r) == (AW+2)'(back_r)) ||
    ((AW+2)'(front_r) + (AW+2)'(count_r) == (AW+2)'(back_r) + (AW+2)'(DEPTH)))

endmodule

// File: verif/deque_shadow_pkg.sv
// Shadow copy of the deque and the store of results it predicts.
package deque_shadow_pkg;
  import dq_pkg::*;

  localparam int DQ_DEPTH  = 1024;
  localparam int DQ_DATA_W = 32;
  localparam int DQ_CNT_W  = 11;
  localparam int DQ_PTR_W  = 10;

  // codes the block must treat as no-ops
  localparam req_t REQ_RSVD_6 = 3'd6;
  localparam req_t REQ_RSVD_7 = 3'd7;

  typedef logic signed [DQ_DATA_W-1:0] word_t;

  typedef struct packed {
    word_t               value;
    logic                value_valid;
    logic [DQ_CNT_W-1:0] occupancy;
    logic                is_empty;
    logic                dropped;
  } deque_result_t;

  class deque_shadow;
    word_t               ring [DQ_DEPTH];
    logic [DQ_PTR_W-1:0] head_idx;
    logic [DQ_PTR_W-1:0] tail_idx;
    int unsigned         fill;
    deque_result_t       pending_results [$];
    int unsigned         mismatches;

    function new();
      head_idx    = '0;
      tail_idx    = '0;
      fill        = 0;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Apply one accepted item to the shadow and queue the result it yields.
    function void take_request(req_t req, word_t data);
      deque_result_t       r;
      logic [DQ_PTR_W-1:0] last_idx;
      r.value       = '1;
      r.value_valid = 1'b0;
      r.dropped     = 1'b0;
      last_idx      = tail_idx - 1'b1;
      case (req)
        REQ_PUSH_FRONT: begin
          if (fill == DQ_DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            head_idx = head_idx - 1'b1;
            ring[head_idx] = data;
            fill++;
          end
        end
        REQ_PUSH_BACK: begin
          if (fill == DQ_DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            ring[tail_idx] = data;
            tail_idx = tail_idx + 1'b1;
            fill++;
          end
        end
        REQ_POP_FRONT: begin
          if (fill != 0) begin
            r.value       = ring[head_idx];
            r.value_valid = 1'b1;
            head_idx      = head_idx + 1'b1;
            fill--;
          end
        end
        REQ_POP_BACK: begin
          if (fill != 0) begin
            tail_idx      = last_idx;
            r.value       = ring[tail_idx];
            r.value_valid = 1'b1;
            fill--;
          end
        end
        REQ_PEEK_FRONT: begin
          if (fill != 0) begin
            r.value       = ring[head_idx];
            r.value_valid = 1'b1;
          end
        end
        REQ_PEEK_BACK: begin
          if (fill != 0) begin
            r.value       = ring[last_idx];
            r.value_valid = 1'b1;
          end
        end
        default: ;
      endcase
      r.occupancy = fill[DQ_CNT_W-1:0];
      r.is_empty  = (fill == 0);
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    task compare_result(word_t value, logic value_valid, logic [DQ_CNT_W-1:0] occupancy,
                        logic is_empty, logic dropped);
      deque_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding", 1, 0);
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) report_mismatch("value_out", value, want.value);
      if (value_valid !== want.value_valid)
        report_mismatch("value_valid", value_valid, want.value_valid);
      if (occupancy !== want.occupancy)
        report_mismatch("occupancy", occupancy, want.occupancy);
      if (is_empty !== want.is_empty) report_mismatch("is_empty", is_empty, want.is_empty);
      if (dropped !== want.dropped) report_mismatch("dropped", dropped, want.dropped);
    endtask
  endclass

endpackage

// File: verif/tb_double_ended_queue_top.sv
// Testbench for the deque: directed and random requests against a shadow deque.
module tb_double_ended_queue_top;
  import dq_pkg::*;
  import deque_shadow_pkg::*;

  localparam int unsigned RUN_LIMIT = 200000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                start       = 1'b0;
  req_t                in_req_type = REQ_PUSH_FRONT;
  word_t               in_value_in = '0;
  logic                busy;
  logic                out_valid;
  word_t               out_value_out;
  logic                out_value_valid;
  logic [DQ_CNT_W-1:0] out_occupancy;
  logic                out_is_empty;
  logic                out_dropped;

  deque_shadow shadow;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  bit          no_gaps    = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  double_ended_queue_top #(
    .DEPTH      (DQ_DEPTH),
    .DATA_WIDTH (DQ_DATA_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_value_out   (out_value_out),
    .out_value_valid (out_value_valid),
    .out_occupancy   (out_occupancy),
    .out_is_empty    (out_is_empty),
    .out_dropped     (out_dropped)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      shadow.compare_result(out_value_out, out_value_valid, out_occupancy, out_is_empty,
                            out_dropped);
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_request(req_t req, word_t data);
    int unsigned gap;
    // every 40 items pick whether this stretch runs back to back
    if (items_sent % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       = 1'b1;
    in_req_type = req;
    in_value_in = data;
    do @(posedge clk); while (busy);
    shadow.take_request(req, data);
    items_sent++;
    @(negedge clk);
  endtask

  // fifo_pct biases pushes to the back and pops/peeks to the front, so that
  // both pointers travel around the ring.
  task automatic random_request(int unsigned push_pct, int unsigned fifo_pct);
    int unsigned roll;
    bit          fifo_side;
    req_t        req;
    roll      = $urandom_range(0, 99);
    fifo_side = ($urandom_range(0, 99) < fifo_pct);
    if (roll < 2)
      req = roll[0] ? REQ_RSVD_7 : REQ_RSVD_6;
    else if (roll < 2 + push_pct)
      req = fifo_side ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    else if (roll[0])
      req = fifo_side ? REQ_POP_FRONT : REQ_POP_BACK;
    else
      req = fifo_side ? REQ_PEEK_FRONT : REQ_PEEK_BACK;
    send_request(req, $urandom);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
  endtask

  initial begin
    shadow = new();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // empty queue: every read and the unused codes
    send_request(REQ_POP_FRONT, 32'sh1234_5678);
    send_request(REQ_POP_BACK, 32'sh7FFF_FFFF);
    send_request(REQ_PEEK_FRONT, 32'sh8000_0000);
    send_request(REQ_PEEK_BACK, -32'sd1);
    send_request(REQ_RSVD_6, 32'sd0);
    send_request(REQ_RSVD_7, -32'sd1);
    // value extremes at both ends, front push wraps the head pointer
    send_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'sh8000_0000);
    send_request(REQ_PUSH_FRONT, -32'sd1);
    send_request(REQ_PUSH_BACK, 32'sd0);
    send_request(REQ_PEEK_FRONT, 32'sd0);
    send_request(REQ_PEEK_BACK, -32'sd1);
    send_request(REQ_RSVD_6, 32'sh5555_5555);
    send_request(REQ_RSVD_7, 32'shAAAA_AAAA);
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_PEEK_BACK, 32'sd0);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_PEEK_BACK, 32'sd0);
    wait_drained();

    // shallow occupancy, frequent trips through empty
    repeat (250) random_request(35, 50);
    wait_drained();
    // fill to capacity, then hover at full so pushes get dropped
    while (shadow.fill < DQ_DEPTH) random_request(95, 85);
    repeat (250) random_request(35, 85);
    wait_drained();

    repeat (4) @(posedge clk);
    if (shadow.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
